// File: src/rgpq_pkg.sv
// Shared types and constants for the resource grant priority queue.
package rgpq_pkg;
  localparam int MaxRes = 16;
  localparam int QDepth = 8;
  localparam int SlotW = $clog2(MaxRes);
  localparam int TotW = $clog2(MaxRes + 1);
  localparam int QPosW = $clog2(QDepth);
  localparam int QCntW = $clog2(QDepth + 1);
  localparam int QAddrW = SlotW + QPosW;
  localparam int EntW = 24;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_ENQ = 3'd1;
  localparam logic [2:0] KIND_GRANT = 3'd2;
  localparam logic [2:0] KIND_RET = 3'd3;
  localparam logic [2:0] KIND_CANCEL = 3'd4;

  localparam logic [3:0] ST_ADDED = 4'd0;
  localparam logic [3:0] ST_ENQUEUED = 4'd1;
  localparam logic [3:0] ST_GRANTED = 4'd2;
  localparam logic [3:0] ST_REFUSED = 4'd3;
  localparam logic [3:0] ST_RETURNED = 4'd4;
  localparam logic [3:0] ST_RET_GRANTED = 4'd5;
  localparam logic [3:0] ST_CANCELLED = 4'd6;
  localparam logic [3:0] ST_NOT_QUEUED = 4'd7;
  localparam logic [3:0] ST_UNKNOWN = 4'd8;
  localparam logic [3:0] ST_FULL = 4'd9;

  typedef struct packed {
    logic [2:0] kind;
    logic [15:0] resource_key;
    logic [15:0] requester_id;
    logic [7:0] level;
    logic [7:0] initial_units;
  } cmd_t;

  localparam int CmdW = $bits(cmd_t);
endpackage

// File: src/resource_grant_priority_queue.sv
// Top level of the resource grant priority queue.
// Usage:
//   Input channel: in_valid/in_stall with kind, resource_key, requester_id,
//   level and initial_units. One word in gives exactly one result word out.
//   Output channel: out_valid/out_stall with status, served_id,
//   resource_index, units_left and queue_count.
// A two-word command queue sits in front of a sequencer, so input can be
// taken while a result waits on a stalled receiver.
// Sequencing: an add, or an unknown kind, is answered straight from idle. Other
//   kinds search the key table one slot at a time (key RAM read port), then walk
//   the queue RAM: a scan reads one entry at a time and a shift moves one entry
//   at a time. Words are handled one at a time.
// Reset (rst, synchronous) empties the table and the command queue; table
//   and queue RAMs hold stale data that is never read.
// When out_stall is high the result holds and the sequencer does not start
//   a new word until it has been taken.
module resource_grant_priority_queue import rgpq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [15:0] resource_key,
  input  logic [15:0] requester_id,
  input  logic [7:0]  level,
  input  logic [7:0]  initial_units,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic [15:0] served_id,
  output logic [3:0]  resource_index,
  output logic [7:0]  units_left,
  output logic [3:0]  queue_count
);
  cmd_t in_cmd;
  cmd_t cq_cmd;
  logic cq_valid;
  logic cq_pop;

  assign in_cmd = '{kind, resource_key, requester_id, level, initial_units};

  rgpq_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .cq_valid(cq_valid), .cq_cmd(cq_cmd), .cq_pop(cq_pop)
  );

  rgpq_back u_back (
    .clk(clk), .rst(rst), .cq_valid(cq_valid), .cq_cmd(cq_cmd), .cq_pop(cq_pop),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .served_id(served_id), .resource_index(resource_index),
    .units_left(units_left), .queue_count(queue_count)
  );

  // a popped word never coincides with a pending result
  a_pop_free: assert property (@(posedge clk) disable iff (rst)
    cq_pop |-> !out_valid) else $error("pop with pending result");
  // result status is always a defined code
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_FULL) else $error("bad status");
  // queue count never exceeds depth
  a_qcnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> queue_count <= 4'(QDepth)) else $error("bad count");
endmodule

// File: src/rgpq_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module rgpq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/rgpq_front.sv
// Front end: input word capture and a two-entry command queue.
module rgpq_front import rgpq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  cmd_t       in_cmd,
  output logic       cq_valid,
  output cmd_t       cq_cmd,
  input  logic       cq_pop
);
  cmd_t q [2];
  logic [1:0] cnt;
  logic rd;
  logic push;

  assign in_stall = (cnt == 2'd2);
  assign push = in_valid && !in_stall;
  assign cq_valid = (cnt != 2'd0);
  assign cq_cmd = q[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      rd <= 1'b0;
    end else begin
      if (push) begin
        q[rd ^ cnt[0]] <= in_cmd;
      end
      if (cq_pop) begin
        rd <= ~rd;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, cq_pop};
    end
  end
endmodule

// File: src/rgpq_back.sv
// Back end: key search, queue update sequencer and result register.
module rgpq_back import rgpq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cq_valid,
  input  cmd_t        cq_cmd,
  output logic        cq_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic [15:0] served_id,
  output logic [3:0]  resource_index,
  output logic [7:0]  units_left,
  output logic [3:0]  queue_count
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_SWAIT = 4'd2;
  localparam logic [3:0] S_DISP = 4'd3;
  localparam logic [3:0] S_QRD = 4'd4;
  localparam logic [3:0] S_QCHK = 4'd5;
  localparam logic [3:0] S_SHR = 4'd6;
  localparam logic [3:0] S_SHW = 4'd7;
  localparam logic [3:0] S_SHL = 4'd8;
  localparam logic [3:0] S_SLW = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0] state;
  cmd_t cmd;
  logic [TotW-1:0] total;
  logic [TotW-1:0] idx;
  logic [SlotW-1:0] slot;
  logic [7:0] units [MaxRes];
  logic [QCntW-1:0] wcnt [MaxRes];
  logic [QCntW-1:0] pos;
  logic [QCntW-1:0] j;
  logic grant;
  logic [3:0] st;
  logic [15:0] srv;

  logic key_we;
  logic [SlotW-1:0] key_ra;
  logic [15:0] key_rd;
  logic q_we;
  logic [QAddrW-1:0] q_wa;
  logic [EntW-1:0] q_wd;
  logic [QAddrW-1:0] q_ra;
  logic [EntW-1:0] q_rd;

  logic [7:0] cur_u;
  logic [QCntW-1:0] cur_n;
  assign cur_u = units[slot];
  assign cur_n = wcnt[slot];

  // the key is written in the pop cycle, straight from the queue head
  rgpq_ram #(.Width(16), .Depth(MaxRes)) u_keys (
    .clk(clk), .we(key_we), .waddr(total[SlotW-1:0]), .wdata(cq_cmd.resource_key),
    .raddr(key_ra), .rdata(key_rd)
  );
  rgpq_ram #(.Width(EntW), .Depth(MaxRes * QDepth)) u_q (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd)
  );

  assign key_ra = idx[SlotW-1:0];
  assign key_we = (state == S_IDLE) && cq_valid && !out_valid
                  && cq_cmd.kind == KIND_ADD && total != TotW'(MaxRes);
  assign cq_pop = (state == S_IDLE) && cq_valid && !out_valid;

  // queue RAM read address: entry j of current slot
  assign q_ra = {slot, j[QPosW-1:0]};

  always_comb begin
    q_we = 1'b0;
    q_wa = {slot, j[QPosW-1:0]};
    q_wd = q_rd;
    if (state == S_SHW) begin
      q_we = 1'b1;
      q_wa = {slot, QPosW'(j + QCntW'(1))};
    end else if (state == S_SLW) begin
      q_we = 1'b1;
      q_wa = {slot, QPosW'(j - QCntW'(1))};
    end else if (state == S_DONE && cmd.kind == KIND_ENQ && st == ST_ENQUEUED) begin
      q_we = 1'b1;
      q_wa = {slot, pos[QPosW-1:0]};
      q_wd = {cmd.requester_id, cmd.level};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cq_pop) begin
            cmd <= cq_cmd;
            idx <= '0;
            srv <= '0;
            grant <= 1'b0;
            if (cq_cmd.kind == KIND_ADD) begin
              if (total == TotW'(MaxRes)) begin
                status <= ST_FULL; served_id <= '0; resource_index <= '0;
                units_left <= '0; queue_count <= '0;
              end else begin
                units[total[SlotW-1:0]] <= cq_cmd.initial_units;
                wcnt[total[SlotW-1:0]] <= '0;
                status <= ST_ADDED; served_id <= '0;
                resource_index <= 4'(total);
                units_left <= cq_cmd.initial_units; queue_count <= '0;
                total <= total + TotW'(1);
              end
              out_valid <= 1'b1;
            end else if (cq_cmd.kind > KIND_CANCEL || total == '0) begin
              status <= ST_UNKNOWN; served_id <= '0; resource_index <= '0;
              units_left <= '0; queue_count <= '0;
              out_valid <= 1'b1;
            end else begin
              state <= S_SRCH;
            end
          end
        end
        S_SRCH: state <= S_SWAIT;  // key read in flight
        S_SWAIT: begin
          if (key_rd == cmd.resource_key) begin
            slot <= idx[SlotW-1:0];
            state <= S_DISP;
          end else if (idx + TotW'(1) >= total) begin
            status <= ST_UNKNOWN; served_id <= '0; resource_index <= '0;
            units_left <= '0; queue_count <= '0;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx <= idx + TotW'(1);
            state <= S_SRCH;
          end
        end
        S_DISP: begin
          j <= '0;
          pos <= cur_n;
          case (cmd.kind)
            KIND_ENQ: begin
              if (cur_n == QCntW'(QDepth)) begin
                st <= ST_FULL; state <= S_DONE;
              end else if (cur_n == '0) begin
                st <= ST_ENQUEUED; state <= S_DONE;
              end else begin
                state <= S_QRD;
              end
            end
            KIND_GRANT, KIND_RET: begin
              logic [7:0] u;
              u = cur_u;
              if (cmd.kind == KIND_RET && u != 8'hFF) u = u + 8'd1;
              if (u != '0 && cur_n != '0) begin
                units[slot] <= u - 8'd1;
                grant <= 1'b1;
                st <= (cmd.kind == KIND_RET) ? ST_RET_GRANTED : ST_GRANTED;
                state <= S_QRD;
              end else begin
                units[slot] <= u;
                st <= (cmd.kind == KIND_RET) ? ST_RETURNED : ST_REFUSED;
                state <= S_DONE;
              end
            end
            default: begin
              st <= ST_NOT_QUEUED;
              state <= (cur_n == '0) ? S_DONE : S_QRD;
            end
          endcase
        end
        S_QRD: state <= S_QCHK;
        S_QCHK: begin
          if (cmd.kind == KIND_ENQ) begin
            if (cmd.level < q_rd[7:0]) begin
              pos <= j; st <= ST_ENQUEUED;
              j <= cur_n - QCntW'(1);
              state <= S_SHR;
            end else if (j + QCntW'(1) == cur_n) begin
              st <= ST_ENQUEUED; state <= S_DONE;
            end else begin
              j <= j + QCntW'(1); state <= S_QRD;
            end
          end else if (grant || q_rd[23:8] == cmd.requester_id) begin
            srv <= q_rd[23:8];
            if (!grant) st <= ST_CANCELLED;
            j <= j + QCntW'(1);
            state <= S_SHL;
          end else if (j + QCntW'(1) == cur_n) begin
            state <= S_DONE;
          end else begin
            j <= j + QCntW'(1); state <= S_QRD;
          end
        end
        // shift right from the tail down to pos
        S_SHR: state <= S_SHW;
        S_SHW: begin
          if (j == pos) state <= S_DONE;
          else begin j <= j - QCntW'(1); state <= S_SHR; end
        end
        // shift left from the removed entry to the tail
        S_SHL: begin
          if (j >= cur_n) begin
            wcnt[slot] <= cur_n - QCntW'(1);
            state <= S_DONE;
          end else state <= S_SLW;
        end
        S_SLW: begin
          j <= j + QCntW'(1); state <= S_SHL;
        end
        S_DONE: begin
          if (cmd.kind == KIND_ENQ && st == ST_ENQUEUED) begin
            wcnt[slot] <= cur_n + QCntW'(1);
          end
          status <= st;
          served_id <= srv;
          resource_index <= 4'(slot);
          units_left <= cur_u;
          queue_count <= 4'((cmd.kind == KIND_ENQ && st == ST_ENQUEUED)
                            ? cur_n + QCntW'(1) : cur_n);
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: dv/resource_grant_priority_queue_test.sv
// Self-checking testbench for the resource grant priority queue.
`timescale 1ns / 100ps

module resource_grant_priority_queue_test;
  import rgpq_pkg::*;

  localparam int NumRandom = 1830;
  localparam int IdleLimit = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  kind = '0;
  logic [15:0] resource_key = '0;
  logic [15:0] requester_id = '0;
  logic [7:0]  level = '0;
  logic [7:0]  initial_units = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  status;
  logic [15:0] served_id;
  logic [3:0]  resource_index;
  logic [7:0]  units_left;
  logic [3:0]  queue_count;

  always #4 clk = ~clk;

  resource_grant_priority_queue dut (.*);

  // One result word as the block reports it.
  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] served_id;
    logic [3:0]  resource_index;
    logic [7:0]  units_left;
    logic [3:0]  queue_count;
  } grant_result_t;

  // Shadow copy of the resource table.
  int unsigned     tbl_total;
  logic [15:0]     tbl_keys   [MaxRes];
  logic [7:0]      tbl_units  [MaxRes];
  int unsigned     tbl_waits  [MaxRes];
  logic [15:0]     tbl_ids    [MaxRes][QDepth];
  logic [7:0]      tbl_levels [MaxRes][QDepth];

  grant_result_t pending_results[$];
  int unsigned   error_count;
  int unsigned   words_in;
  int unsigned   words_out;
  int unsigned   idle_cycles;
  bit            hold_output;   // receiver hold-off in force
  bit            quiet_phase;   // stretch with no random idling
  bit            stim_done;
  int            status_seen[16];

  // Drop entry pos of a slot's queue, closing the gap.
  function automatic void drop_waiter(int s, int pos);
    for (int i = pos; i + 1 < tbl_waits[s]; i++) begin
      tbl_ids[s][i] = tbl_ids[s][i+1];
      tbl_levels[s][i] = tbl_levels[s][i+1];
    end
    tbl_waits[s]--;
  endfunction

  // Serve the queue head if a unit is free; returns 1 when served.
  function automatic bit serve_head(int s, output logic [15:0] who);
    who = '0;
    if (tbl_units[s] > 0 && tbl_waits[s] > 0) begin
      who = tbl_ids[s][0];
      drop_waiter(s, 0);
      tbl_units[s]--;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one command to the shadow table and return the expected result.
  function automatic grant_result_t grant_outcome(cmd_t c);
    grant_result_t r;
    int s;
    int pos;
    logic [15:0] who;
    r = '0;
    r.status = ST_UNKNOWN;
    s = -1;
    if (c.kind == KIND_ADD) begin
      if (tbl_total >= MaxRes) begin
        r.status = ST_FULL;
      end else begin
        s = tbl_total;
        tbl_keys[s] = c.resource_key;
        tbl_units[s] = c.initial_units;
        tbl_waits[s] = 0;
        tbl_total++;
        r.status = ST_ADDED;
      end
    end else if (c.kind <= KIND_CANCEL) begin
      for (int i = 0; i < tbl_total; i++) begin
        if (tbl_keys[i] == c.resource_key) begin
          s = i;
          break;
        end
      end
      if (s >= 0) begin
        case (c.kind)
          KIND_ENQ: begin
            if (tbl_waits[s] >= QDepth) begin
              r.status = ST_FULL;
            end else begin
              pos = tbl_waits[s];
              for (int i = 0; i < tbl_waits[s]; i++) begin
                if (c.level < tbl_levels[s][i]) begin
                  pos = i;
                  break;
                end
              end
              for (int i = tbl_waits[s]; i > pos; i--) begin
                tbl_ids[s][i] = tbl_ids[s][i-1];
                tbl_levels[s][i] = tbl_levels[s][i-1];
              end
              tbl_ids[s][pos] = c.requester_id;
              tbl_levels[s][pos] = c.level;
              tbl_waits[s]++;
              r.status = ST_ENQUEUED;
            end
          end
          KIND_GRANT: begin
            r.status = serve_head(s, who) ? ST_GRANTED : ST_REFUSED;
            r.served_id = who;
          end
          KIND_RET: begin
            if (tbl_units[s] != 8'hff) tbl_units[s]++;
            r.status = ST_RETURNED;
            if (serve_head(s, who)) begin
              r.status = ST_RET_GRANTED;
              r.served_id = who;
            end
          end
          default: begin
            r.status = ST_NOT_QUEUED;
            for (int i = 0; i < tbl_waits[s]; i++) begin
              if (tbl_ids[s][i] == c.requester_id) begin
                r.served_id = c.requester_id;
                drop_waiter(s, i);
                r.status = ST_CANCELLED;
                break;
              end
            end
          end
        endcase
      end
    end
    if (s >= 0) begin
      r.resource_index = s[3:0];
      r.units_left = tbl_units[s];
      r.queue_count = tbl_waits[s][3:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", words_out, what, got, want);
    error_count++;
  endtask

  // Directed table; has_exp rows carry a hand-written result.
  typedef struct {
    cmd_t          c;
    bit            has_exp;
    grant_result_t e;
  } directed_row_t;

  directed_row_t directed_rows[$];

  function automatic directed_row_t row(logic [2:0] k, logic [15:0] key, logic [15:0] rid,
                                        logic [7:0] lvl, logic [7:0] u, bit he = 0,
                                        grant_result_t e = '0);
    directed_row_t d;
    d.c = '{k, key, rid, lvl, u};
    d.has_exp = he;
    d.e = e;
    return d;
  endfunction

  // Drive one word and wait until the block takes it. Valid stays high
  // after acceptance so back-to-back words need one drive per edge.
  task automatic send_word(cmd_t c);
    while (!quiet_phase && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {kind, resource_key, requester_id, level, initial_units} <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(grant_outcome(c));
    words_in++;
  endtask

  // Drop valid after the last word of a burst.
  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic cmd_t random_word(int nkeys);
    cmd_t c;
    int r;
    r = $urandom_range(99);
    c.kind = (r < 8) ? KIND_ADD : (r < 40) ? KIND_ENQ : (r < 60) ? KIND_GRANT :
             (r < 80) ? KIND_RET : (r < 95) ? KIND_CANCEL : 3'($urandom_range(7, 5));
    // Mostly keys from a small live set so lookups hit.
    c.resource_key = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(nkeys));
    if ($urandom_range(19) == 0) c.resource_key = 16'hffff;
    c.requester_id = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(15));
    c.level = ($urandom_range(1) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    c.initial_units = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(2));
    return c;
  endfunction

  // Receiver: random stalls plus the long hold-off.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_output || (!quiet_phase && $urandom_range(99) < 7);
  end

  // Result checker.
  always @(posedge clk) begin
    grant_result_t want;
    if (!rst && out_valid && !out_stall) begin
      words_out++;
      if (pending_results.size() == 0) begin
        $display("unexpected result word, status %0d", status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        status_seen[status]++;
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (served_id !== want.served_id) report_mismatch("served_id", served_id, want.served_id);
        if (resource_index !== want.resource_index)
          report_mismatch("resource_index", resource_index, want.resource_index);
        if (units_left !== want.units_left)
          report_mismatch("units_left", units_left, want.units_left);
        if (queue_count !== want.queue_count)
          report_mismatch("queue_count", queue_count, want.queue_count);
      end
    end
  end

  // Watchdog: cycles with no word moving on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit && !(stim_done && pending_results.size() == 0)) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Compare a directed row's typed-in result with the predicted one.
  task automatic check_row(directed_row_t d, grant_result_t predicted);
    if (d.has_exp && predicted !== d.e) begin
      $display("directed row kind %0d key %0h: table disagrees with prediction",
               d.c.kind, d.c.resource_key);
      error_count++;
    end
  endtask

  initial begin
    int nkeys;
    directed_row_t d;
    tbl_total = 0;
    error_count = 0;
    words_in = 0;
    words_out = 0;
    hold_output = 0;
    quiet_phase = 0;
    stim_done = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table: every lookup is unknown; then edge keys and queue order.
    directed_rows.push_back(row(KIND_GRANT, 16'h0000, 0, 0, 0, 1, '{ST_UNKNOWN, 0, 0, 0, 0}));
    directed_rows.push_back(row(3'd7, 16'hffff, 16'hffff, 8'hff, 8'hff, 1,
                                '{ST_UNKNOWN, 0, 0, 0, 0}));
    directed_rows.push_back(row(KIND_ADD, 16'hffff, 0, 0, 8'hfe, 1, '{ST_ADDED, 0, 0, 8'hfe, 0}));
    directed_rows.push_back(row(KIND_ADD, 16'h0000, 0, 0, 8'h00, 1, '{ST_ADDED, 0, 1, 0, 0}));
    directed_rows.push_back(row(KIND_ADD, 16'hffff, 0, 0, 8'h05, 1, '{ST_ADDED, 0, 2, 5, 0}));
    directed_rows.push_back(row(KIND_RET, 16'hffff, 0, 0, 0, 1, '{ST_RETURNED, 0, 0, 8'hff, 0}));
    directed_rows.push_back(row(KIND_RET, 16'hffff, 0, 0, 0, 1, '{ST_RETURNED, 0, 0, 8'hff, 0}));
    directed_rows.push_back(row(KIND_GRANT, 16'h0000, 0, 0, 0, 1, '{ST_REFUSED, 0, 1, 0, 0}));
    for (int i = 0; i < 9; i++)
      directed_rows.push_back(row(KIND_ENQ, 16'h0000, 16'(16'hfff0 + i),
                                  (i % 3 == 0) ? 8'hff : 8'(i % 2), 0));
    directed_rows.push_back(row(KIND_CANCEL, 16'h0000, 16'h1234, 0, 0));
    directed_rows.push_back(row(KIND_CANCEL, 16'h0000, 16'hfff3, 0, 0));
    directed_rows.push_back(row(KIND_RET, 16'h0000, 0, 0, 0));
    directed_rows.push_back(row(KIND_GRANT, 16'h0000, 0, 0, 0));
    directed_rows.push_back(row(KIND_RET, 16'h0000, 0, 0, 0));
    directed_rows.push_back(row(KIND_GRANT, 16'h0000, 0, 0, 0));
    for (int i = 0; i < directed_rows.size(); i++) begin
      d = directed_rows[i];
      send_word(d.c);
      check_row(d, pending_results[$]);
    end

    // Fill the table to the limit, then one more add.
    while (tbl_total < MaxRes) send_word('{KIND_ADD, 16'(tbl_total), 0, 0, 8'(tbl_total % 3)});
    send_word('{KIND_ADD, 16'h4242, 0, 0, 8'h01});
    stop_sending();

    // Sender pause until every result is back.
    wait (pending_results.size() == 0);

    // Receiver holds off while the sender keeps offering words.
    fork
      begin
        hold_output = 1;
        repeat (300) @(posedge clk);
        hold_output = 0;
      end
      for (int i = 0; i < 20; i++) send_word(random_word(15));
    join

    // Random traffic; a reset-free table stays full, so later phases draw
    // keys 0 to 15, most of them live in the table, with random queues.
    nkeys = 15;
    for (int i = 0; i < NumRandom; i++) begin
      quiet_phase = (i >= 600 && i < 900);
      send_word(random_word(nkeys));
    end
    stop_sending();
    quiet_phase = 0;
    stim_done = 1;

    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk);
    $display("%0d words sent, %0d results checked; granted %0d, returned_granted %0d,",
             words_in, words_out, status_seen[ST_GRANTED], status_seen[ST_RET_GRANTED]);
    $display("cancelled %0d, not_queued %0d, unknown %0d, full %0d",
             status_seen[ST_CANCELLED], status_seen[ST_NOT_QUEUED],
             status_seen[ST_UNKNOWN], status_seen[ST_FULL]);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
